FILE: design/mtbr_pkg.sv
// Package holding the constants, types and word functions of the byte generator.
package mtbr_pkg;

    localparam int unsigned POOL_WORDS_DEF = 624;
    localparam int unsigned TWIST_OFFSET   = 397;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned SEED_W         = 8;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned BYTE_LSB       = 20;

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
    localparam logic [31:0] INIT_MULT    = 32'h6C07_8965;
    localparam logic [31:0] SEED_PRIME_A = 32'd685956421;
    localparam logic [31:0] SEED_PRIME_B = 32'd567498787;
    localparam logic [31:0] SEED_PRIME_C = 32'd135768463;
    localparam logic [31:0] SEED_PRIME_D = 32'd954167527;

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    // Words at the fixed taps of the pool chain.
    typedef struct packed {
        t_word head;
        t_word next;
        t_word mid;
        t_word tail;
    } t_taps;

    // First pool word: the sign-extended seed times four primes, XORed.
    function automatic t_word seed_word0(input logic signed [SEED_W-1:0] seed);
        t_word x;
        x = {{(WORD_W-SEED_W){seed[SEED_W-1]}}, seed};
        return (x * SEED_PRIME_A) ^ (x * SEED_PRIME_B)
             ^ (x * SEED_PRIME_C) ^ (x * SEED_PRIME_D);
    endfunction

    // One step of the standard initialisation recurrence, without the index term.
    function automatic t_word init_step(input t_word prev);
        return INIT_MULT * (prev ^ (prev >> 30));
    endfunction

    // New value of one pool word from its own, its neighbour and the far tap.
    function automatic t_word twist_word(input t_word cur, input t_word nxt,
                                         input t_word far);
        t_word y;
        t_word v;
        y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
        v = far ^ (y >> 1);
        if (y[0]) begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

    function automatic t_word temper(input t_word w);
        t_word y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

FILE: design/mtbr_if.sv
// Handshake interfaces for the command channel and the random byte channel.
interface mtbr_cmd_if;
    import mtbr_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [SEED_W-1:0]  seed_value;

    modport source (output valid, output command, output seed_value, input ready);
    modport sink   (input valid, input command, input seed_value, output ready);
endinterface

interface mtbr_byte_if;
    import mtbr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] random_byte;

    modport source (output valid, output random_byte, input ready);
    modport sink   (input valid, input random_byte, output ready);
endinterface

FILE: design/mtbr_cell.sv
// One cell of the pool chain: a single pool word that loads from its neighbour.
module mtbr_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  mtbr_pkg::t_word i_word,
    output mtbr_pkg::t_word o_word
);
    import mtbr_pkg::*;

    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;

endmodule

FILE: design/mtbr_chain.sv
// Row of pool cells that all move one place towards the head on a shift.
module mtbr_chain #(
    parameter int unsigned POOL_WORDS = mtbr_pkg::POOL_WORDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_shift,
    input  mtbr_pkg::t_word i_tail_word,
    output mtbr_pkg::t_taps o_taps
);
    import mtbr_pkg::*;

    t_word w_q [POOL_WORDS];

    for (genvar k = 0; k < POOL_WORDS; k++) begin : g_cell
        t_word w_d;
        if (k == POOL_WORDS - 1) begin : g_tail
            assign w_d = i_tail_word;
        end else begin : g_body
            assign w_d = w_q[k+1];
        end
        mtbr_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_word  (w_d),
            .o_word  (w_q[k])
        );
    end

    assign o_taps.head = w_q[0];
    assign o_taps.next = w_q[1];
    assign o_taps.mid  = w_q[TWIST_OFFSET];
    assign o_taps.tail = w_q[POOL_WORDS-1];

endmodule

FILE: design/mersenne_twister_byte_rng.sv
// Top level of the MT19937 byte generator: sequencer, configuration register and outputs.
//
//   Channel     Direction  Handshake          Word contents
//   i_cmd       in         valid / ready      command, seed_value
//   o_byte      out        valid / ready      random_byte
//   i_cfg_*     in         write enable only  boot seed (8 bits, signed)
//
// A read that finds the read position away from the start of the pool is accepted and
// then delivered. At the start of the pool a twist comes first and rewrites every word,
// since the chain moves one word past the twist taps each cycle.
// A seed fills the chain, then rotates it forward by the current read position to bring
// that word back to the head; a read before any seed pays this first.
// Reset is synchronous and active low; it clears the sequencer, the read position, the
// seeded flag and the boot seed, but not the pool words, which are written before use.
// A new word is taken only while the sequencer is idle; a finished byte waits in the
// output register while the next command is taken, and a second byte stalls in the
// delivery state until the output register is free.
module mersenne_twister_byte_rng #(
    parameter int unsigned POOL_WORDS = mtbr_pkg::POOL_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic signed [mtbr_pkg::SEED_W-1:0] i_cfg_data,
    mtbr_cmd_if.sink                          i_cmd,
    mtbr_byte_if.source                       o_byte
);
    import mtbr_pkg::*;

    localparam int unsigned CW = $clog2(POOL_WORDS);
    localparam logic [CW-1:0] LAST_WORD = CW'(POOL_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED0,
        S_FILL,
        S_ALIGN,
        S_TWIST,
        S_EMIT
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_pos;
    logic [CW-1:0]            r_count;
    logic                     r_seeded;
    logic                     r_cmd;
    logic signed [SEED_W-1:0] r_seed;
    logic signed [SEED_W-1:0] r_boot_seed;
    logic                     r_out_valid;
    logic [BYTE_W-1:0]        r_byte;

    logic   w_accept;
    logic   w_emit;
    logic   w_shift;
    t_word  w_tail_word;
    t_word  w_tempered;
    t_taps  w_taps;
    t_state w_after_seed;

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign w_accept           = i_cmd.valid && i_cmd.ready;
    assign o_byte.valid       = r_out_valid;
    assign o_byte.random_byte = r_byte;

    // The byte leaves once the output register is empty or is being emptied.
    assign w_emit     = (r_state == S_EMIT) && (!r_out_valid || o_byte.ready);
    assign w_tempered = temper(w_taps.head);

    // Where the sequencer goes once the pool has been seeded and realigned.
    always_comb begin
        if (r_cmd == CMD_READ) begin
            w_after_seed = (r_pos == '0) ? S_TWIST : S_EMIT;
        end else begin
            w_after_seed = S_IDLE;
        end
    end

    // The chain moves in every working state but delivery, where it moves as the byte leaves;
    // the tail takes a new, twisted or recirculated word depending on what the sequencer is doing.
    always_comb begin
        w_shift     = 1'b0;
        w_tail_word = w_taps.head;
        unique case (r_state)
            S_IDLE: begin
                w_shift = 1'b0;
            end
            S_SEED0: begin
                w_shift     = 1'b1;
                w_tail_word = seed_word0(r_seed);
            end
            S_FILL: begin
                w_shift     = 1'b1;
                w_tail_word = init_step(w_taps.tail) + {{(WORD_W-CW){1'b0}}, r_count};
            end
            S_ALIGN: begin
                w_shift = 1'b1;
            end
            S_TWIST: begin
                w_shift     = 1'b1;
                w_tail_word = twist_word(w_taps.head, w_taps.next, w_taps.mid);
            end
            S_EMIT: begin
                w_shift = w_emit;
            end
            default: begin
                w_shift = 1'b0;
            end
        endcase
    end

    mtbr_chain #(
        .POOL_WORDS (POOL_WORDS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_shift     (w_shift),
        .i_tail_word (w_tail_word),
        .o_taps      (w_taps)
    );

    // The boot seed is a plain configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_seed <= '0;
        end else if (i_cfg_we) begin
            r_boot_seed <= i_cfg_data;
        end
    end

    // Sequencer. The head cell always holds the word at the read position while
    // idle, so a seed is followed by rotating the chain forward by that position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_seeded    <= 1'b0;
            r_cmd       <= CMD_SEED;
            r_out_valid <= 1'b0;
        end else begin
            // A delivery refills the output register even while it is being emptied.
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd <= i_cmd.command;
                        if (i_cmd.command == CMD_SEED) begin
                            r_seed  <= i_cmd.seed_value;
                            r_state <= S_SEED0;
                        end else if (!r_seeded) begin
                            r_seed  <= r_boot_seed;
                            r_state <= S_SEED0;
                        end else if (r_pos == '0) begin
                            r_count <= '0;
                            r_state <= S_TWIST;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_SEED0: begin
                    r_count <= CW'(1);
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    if (r_count == LAST_WORD) begin
                        r_seeded <= 1'b1;
                        r_count  <= '0;
                        r_state  <= (r_pos != '0) ? S_ALIGN : w_after_seed;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
                S_ALIGN: begin
                    if (r_count == r_pos - 1'b1) begin
                        r_count <= '0;
                        r_state <= w_after_seed;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
                S_TWIST: begin
                    if (r_count == LAST_WORD) begin
                        r_count <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_byte      <= w_tempered[BYTE_LSB +: BYTE_W];
                        r_pos       <= (r_pos == LAST_WORD) ? '0 : r_pos + 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The read position never leaves the pool.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_WORD)
        else $error("read position beyond the pool");

    // Only a byte delivery moves the read position; seeding leaves it alone.
    a_pos_moves_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_emit |=> $stable(r_pos))
        else $error("read position moved outside a delivery");

    // A byte is only ever taken from a seeded pool, and a twist only at its start.
    a_emit_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_seeded)
        else $error("byte delivered from an unseeded pool");

    a_twist_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TWIST) |-> (r_pos == '0))
        else $error("pool twisted away from its start");

    // A new output word appears only out of the delivery state.
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("output word raised outside a delivery");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the MT19937 byte generator, with its own pool tracker.
module testbench;
    import mtbr_pkg::*;

    localparam int unsigned N_WORDS = POOL_WORDS_DEF;
    // A seed fills the pool and then brings the current read position back
    // to the head. This margin covers both.
    localparam int unsigned SETTLE_CYCLES = 1300;
    localparam int unsigned PHASE_ITEMS   = 150;

    // The scoreboard keeps its own copy of the pool, the read position and the
    // seeded flag. It works out the byte for every accepted read word and
    // compares the bytes that come out, in order.
    class mt_byte_checker;
        bit [WORD_W-1:0]        pool_words [N_WORDS];
        int unsigned            read_pos;
        bit                     seeded;
        bit signed [SEED_W-1:0] boot_seed;
        bit [BYTE_W-1:0]        expected_bytes [$];
        int unsigned            mismatches;
        int unsigned            bytes_checked;
        int unsigned            seeds_noted;
        int unsigned            wraps;
        int unsigned            boot_writes;

        function new();
            read_pos      = 0;
            seeded        = 1'b0;
            boot_seed     = '0;
            mismatches    = 0;
            bytes_checked = 0;
            seeds_noted   = 0;
            wraps         = 0;
            boot_writes   = 0;
        endfunction

        function void set_boot_seed(logic signed [SEED_W-1:0] value);
            boot_seed = value;
            boot_writes++;
        endfunction

        // Word zero from the sign-extended seed, the rest by the usual recurrence.
        function void fill_pool(bit signed [SEED_W-1:0] seed);
            bit [WORD_W-1:0] s;
            int unsigned     i;
            s = {{(WORD_W-SEED_W){seed[SEED_W-1]}}, seed};
            pool_words[0] = (s * SEED_PRIME_A) ^ (s * SEED_PRIME_B)
                          ^ (s * SEED_PRIME_C) ^ (s * SEED_PRIME_D);
            for (i = 1; i < N_WORDS; i++) begin
                pool_words[i] = INIT_MULT * (pool_words[i-1] ^ (pool_words[i-1] >> 30))
                              + WORD_W'(i);
            end
            seeded = 1'b1;
        endfunction

        function bit [BYTE_W-1:0] predict_byte();
            bit [WORD_W-1:0] y;
            bit [WORD_W-1:0] v;
            int unsigned     i;
            if (!seeded) begin
                fill_pool(boot_seed);
            end
            // The whole pool is regenerated whenever reading starts from its head.
            if (read_pos == 0) begin
                for (i = 0; i < N_WORDS; i++) begin
                    y = {pool_words[i][WORD_W-1], pool_words[(i + 1) % N_WORDS][WORD_W-2:0]};
                    v = pool_words[(i + TWIST_OFFSET) % N_WORDS] ^ (y >> 1);
                    if (y[0]) begin
                        v = v ^ TWIST_MATRIX;
                    end
                    pool_words[i] = v;
                end
            end
            y = pool_words[read_pos];
            y = y ^ (y >> 11);
            y = y ^ ((y << 7) & TEMPER_B);
            y = y ^ ((y << 15) & TEMPER_C);
            y = y ^ (y >> 18);
            read_pos++;
            if (read_pos == N_WORDS) begin
                read_pos = 0;
                wraps++;
            end
            return y[BYTE_LSB +: BYTE_W];
        endfunction

        function void note_command(logic command, logic signed [SEED_W-1:0] seed);
            if (command == CMD_SEED) begin
                fill_pool(seed);
                seeds_noted++;
            end else begin
                expected_bytes.push_back(predict_byte());
            end
        endfunction

        function void check_byte(logic [BYTE_W-1:0] actual);
            bit [BYTE_W-1:0] want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected random_byte: expected none, actual %02h",
                         $time, actual);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (actual !== want) begin
                    $display("%0t: random_byte mismatch: expected %02h, actual %02h",
                             $time, want, actual);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic signed [SEED_W-1:0] i_cfg_data;

    mtbr_cmd_if  cmd_bus ();
    mtbr_byte_if byte_bus ();

    mt_byte_checker sb = new();

    // Percentage chance of a command gap after each word or of a receiver stall burst; zero gives calm stretches.
    int unsigned idle_pct   = 15;
    int unsigned reads_sent = 0;
    int unsigned words_sent = 0;

    mersenne_twister_byte_rng dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_bus),
        .o_byte     (byte_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // All handshakes and register writes are observed at the rising edge, using the
    // values that were settled before it, so the order of processes does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_cfg_we) begin
                sb.set_boot_seed(i_cfg_data);
            end
            if (cmd_bus.valid && cmd_bus.ready) begin
                sb.note_command(cmd_bus.command, cmd_bus.seed_value);
            end
            if (byte_bus.valid && byte_bus.ready) begin
                sb.check_byte(byte_bus.random_byte);
            end
        end
    end

    // The byte receiver holds off in bursts while idling is enabled.
    initial begin
        int stall_left;
        stall_left = 0;
        byte_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                byte_bus.ready <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 14) - 1;
                byte_bus.ready <= 1'b0;
            end else begin
                byte_bus.ready <= 1'b1;
            end
        end
    end

    // Offers one word and holds it until it is taken. Valid stays high into the
    // next word unless a gap is drawn, so it is never dropped and raised in one step.
    task automatic send_word(input logic command, input logic signed [SEED_W-1:0] seed);
        cmd_bus.valid      <= 1'b1;
        cmd_bus.command    <= command;
        cmd_bus.seed_value <= seed;
        do @(posedge i_clk); while (!cmd_bus.ready);
        words_sent++;
        if (command == CMD_READ) begin
            reads_sent++;
        end
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Waits for every outstanding byte, then lets a trailing seed finish its fill.
    // The drain is checked on the falling edge, after the monitor has had its turn.
    task automatic wait_until_idle();
        cmd_bus.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_boot_seed(input logic signed [SEED_W-1:0] value);
        wait_until_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_random_word();
        logic                     command;
        logic signed [SEED_W-1:0] seed;
        command = ($urandom_range(0, 99) < 12) ? CMD_SEED : CMD_READ;
        seed    = SEED_W'($urandom_range(0, 255));
        if (command == CMD_SEED && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       seed = -8'sd128;
                1:       seed = 8'sd127;
                2:       seed = 8'sd0;
                default: seed = -8'sd1;
            endcase
        end
        send_word(command, seed);
    endtask

    initial begin
        logic signed [SEED_W-1:0] boot_settings [4];
        int unsigned              n;
        int unsigned              phase;
        boot_settings = '{8'sd127, 8'sd0, -8'sd1, 8'sd1};
        n     = 0;
        phase = 0;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_data         <= '0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.command    <= CMD_READ;
        cmd_bus.seed_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The most negative boot seed is the one that the first reads will use.
        write_boot_seed(-8'sd128);

        // Reads before any seed: the pool is seeded from the boot seed, then
        // twisted because the read position starts at the head.
        send_word(CMD_READ, 8'sd0);
        send_word(CMD_READ, -8'sd128);
        send_word(CMD_READ, 8'sd127);
        // Reseeding mid-pool resumes at the current position with no twist.
        send_word(CMD_SEED, 8'sd127);
        send_word(CMD_READ, 8'sd0);
        send_word(CMD_READ, 8'sd0);
        send_word(CMD_SEED, -8'sd128);
        send_word(CMD_READ, 8'sd0);
        send_word(CMD_READ, -8'sd1);
        send_word(CMD_SEED, 8'sd0);
        send_word(CMD_READ, 8'sd0);
        send_word(CMD_SEED, -8'sd1);
        send_word(CMD_READ, 8'sd0);
        send_word(CMD_SEED, 8'sd1);
        send_word(CMD_READ, 8'sd85);
        // Back-to-back seeds: only the second one should count.
        send_word(CMD_SEED, 8'sd85);
        send_word(CMD_SEED, -8'sd86);
        send_word(CMD_READ, 8'sd0);
        send_word(CMD_READ, 8'sd0);
        send_word(CMD_SEED, 8'sd127);

        // Random phases, each opened with a drain and a new boot seed.
        while (n < 370) begin
            if (n % PHASE_ITEMS == 0) begin
                if (phase < 4) begin
                    write_boot_seed(boot_settings[phase]);
                end else begin
                    write_boot_seed(SEED_W'($urandom_range(0, 255)));
                end
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 12;
                    default: idle_pct = 35;
                endcase
                phase++;
            end
            send_random_word();
            n++;
        end

        // Closing stretch at full rate on both sides.
        idle_pct = 0;
        repeat (60) send_random_word();

        wait_until_idle();
        $display("Sent %0d command words (%0d reads, %0d seeds), checked %0d bytes.",
                 words_sent, reads_sent, sb.seeds_noted, sb.bytes_checked);
        $display("Pool wrapped %0d time(s); boot seed written %0d times.",
                 sb.wraps, sb.boot_writes);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS mersenne_twister_byte_rng");
        end else begin
            $display("FAIL mersenne_twister_byte_rng");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("%0t: timeout with %0d bytes still outstanding", $time, sb.pending());
        $display("FAIL mersenne_twister_byte_rng");
        $finish;
    end

endmodule

FILE: filelist.f
design/mtbr_pkg.sv
design/mtbr_if.sv
design/mtbr_cell.sv
design/mtbr_chain.sv
design/mersenne_twister_byte_rng.sv
dv/testbench.sv
